@@ rtl/sprw_pkg.sv @@
// ----------------------------------------------------------------------------
// sprw_pkg
// Shared types, widths, codes and colour helpers for the scaled pixel
// replicate writer.
// ----------------------------------------------------------------------------
package sprw_pkg;

  localparam int MAX_SCALE_DEF = 8;

  localparam int COORD_W  = 13;
  localparam int CHAN_W   = 8;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 48;
  localparam int SCALE_W  = 4;
  localparam int STRIDE_W = 15;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = ADDR_W;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 104;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic MODE_888 = 1'b0;
  localparam logic MODE_101010 = 1'b1;

  typedef struct packed {
    logic              is_write;
    logic [WORD_W-1:0] word;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              last;
  } sprw_pay_t;

  function automatic logic [9:0] widen10(input logic [CHAN_W-1:0] c);
    widen10 = {c, c[7:6]};
  endfunction

  function automatic logic [WORD_W-1:0] encode_rgb(input logic mode,
                                                   input logic [CHAN_W-1:0] r,
                                                   input logic [CHAN_W-1:0] g,
                                                   input logic [CHAN_W-1:0] b);
    if (mode == MODE_101010) begin
      encode_rgb = {2'b00, widen10(r), widen10(g), widen10(b)};
    end else begin
      encode_rgb = {8'h00, r, g, b};
    end
  endfunction

  // returns {blue, green, red}
  function automatic logic [3*CHAN_W-1:0] decode_rgb(input logic mode,
                                                     input logic [WORD_W-1:0] raw);
    if (mode == MODE_101010) begin
      decode_rgb = {raw[9:2], raw[19:12], raw[29:22]};
    end else begin
      decode_rgb = {raw[7:0], raw[15:8], raw[23:16]};
    end
  endfunction

endpackage

@@ rtl/scaled_pixel_replicate_writer.sv @@
// ----------------------------------------------------------------------------
// scaled_pixel_replicate_writer
// Integer nearest-neighbour upscale: each pixel request becomes scale x scale
// framebuffer writes, or one decoded sample for a read.
//
//   channel | ports                          | content
//   --------+--------------------------------+---------------------------------
//   in      | in_tvalid/tready/tdata/tuser   | pixel request, tuser = operation
//   out     | out_tvalid/tready/tdata/tuser  | write or read result, tlast = last
//          |  /tlast                        |
//   cfg     | cfg_we/cfg_index/cfg_wdata     | register writes, no read-back
//
// One result leaves per cycle while the output is not stalled: a write
// request yields scale*scale results, a read request one; the expander's
// sub-row/sub-column counters set this. A request passes the expander,
// row/column, multiply, index add and address add registers to the output.
// Reset is synchronous and active low; it clears all valid bits and loads the
// register reset values. A stall on the output backs up stage by stage and
// loses nothing; bubbles are filled as they reach a stalled stage.
// ----------------------------------------------------------------------------
module scaled_pixel_replicate_writer #(
  parameter int MAX_SCALE = sprw_pkg::MAX_SCALE_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x[12:0], pos_y[25:13], red_in[33:26], green_in[41:34],
  // blue_in[49:42], raw_word[81:50], zero[87:82]
  input  logic [sprw_pkg::IN_DATA_W-1:0]    in_tdata,
  // operation[0]
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // byte_address[47:0], pixel_word[79:48], red_out[87:80],
  // green_out[95:88], blue_out[103:96]
  output logic [sprw_pkg::OUT_DATA_W-1:0]   out_tdata,
  // is_write[0]
  output logic [0:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [sprw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sprw_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int RCW = sprw_pkg::COORD_W + $clog2(MAX_SCALE + 1);
  localparam int PW  = RCW + sprw_pkg::STRIDE_W;
  localparam int IW  = PW + 1;

  // configuration registers
  logic [sprw_pkg::SCALE_W-1:0]  scale_r;
  logic                          color_mode_r;
  logic [sprw_pkg::STRIDE_W-1:0] stride_r;
  logic [sprw_pkg::ADDR_W-1:0]   base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r      <= sprw_pkg::SCALE_W'(1);
      color_mode_r <= sprw_pkg::MODE_888;
      stride_r     <= sprw_pkg::STRIDE_W'(1);
      base_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sprw_pkg::REG_SCALE:      scale_r      <= cfg_wdata[sprw_pkg::SCALE_W-1:0];
        sprw_pkg::REG_COLOR_MODE: color_mode_r <= cfg_wdata[0];
        sprw_pkg::REG_STRIDE:     stride_r     <= cfg_wdata[sprw_pkg::STRIDE_W-1:0];
        sprw_pkg::REG_FRAME_BASE: base_r       <= cfg_wdata[sprw_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [sprw_pkg::SCALE_W-1:0] s_eff;
  logic [CW-1:0]                s_max;

  always_comb begin
    priority if (scale_r == '0) begin
      s_eff = sprw_pkg::SCALE_W'(1);
    end else if (scale_r > sprw_pkg::SCALE_W'(MAX_SCALE)) begin
      s_eff = sprw_pkg::SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_r;
    end
  end

  assign s_max = CW'(s_eff - sprw_pkg::SCALE_W'(1));

  // input field unpacking
  logic                         in_op;
  logic [sprw_pkg::COORD_W-1:0] in_pos_x;
  logic [sprw_pkg::COORD_W-1:0] in_pos_y;
  logic [sprw_pkg::CHAN_W-1:0]  in_red;
  logic [sprw_pkg::CHAN_W-1:0]  in_green;
  logic [sprw_pkg::CHAN_W-1:0]  in_blue;
  logic [sprw_pkg::WORD_W-1:0]  in_raw;

  assign in_op    = in_tuser[0];
  assign in_pos_x = in_tdata[12:0];
  assign in_pos_y = in_tdata[25:13];
  assign in_red   = in_tdata[33:26];
  assign in_green = in_tdata[41:34];
  assign in_blue  = in_tdata[49:42];
  assign in_raw   = in_tdata[81:50];

  // pipeline ready chain
  logic p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !p4_v_r || out_tready;
  assign rdy3 = !p3_v_r || rdy4;
  assign rdy2 = !p2_v_r || rdy3;
  assign rdy1 = !p1_v_r || rdy2;

  // expander: holds one request and steps through its sub-block
  logic                    e_v_r;
  logic                    e_op_r;
  logic [RCW-1:0]          e_row0_r;
  logic [RCW-1:0]          e_col0_r;
  logic [sprw_pkg::WORD_W-1:0]   e_word_r;
  logic [3*sprw_pkg::CHAN_W-1:0] e_rgb_r;
  logic [CW-1:0]           e_sy_r, e_sy_nxt;
  logic [CW-1:0]           e_sx_r, e_sx_nxt;
  logic                    e_v_nxt;
  logic                    e_last;
  logic                    emit;
  logic                    in_acc;

  assign e_last    = (e_op_r == sprw_pkg::OP_READ) || (e_sx_r == s_max && e_sy_r == s_max);
  assign emit      = e_v_r && rdy1;
  assign in_tready = !e_v_r || (emit && e_last);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    e_v_nxt  = e_v_r;
    e_sx_nxt = e_sx_r;
    e_sy_nxt = e_sy_r;
    priority if (in_acc) begin
      e_v_nxt  = 1'b1;
      e_sx_nxt = '0;
      e_sy_nxt = '0;
    end else if (emit && e_last) begin
      e_v_nxt = 1'b0;
    end else if (emit) begin
      if (e_sx_r == s_max) begin
        e_sx_nxt = '0;
        e_sy_nxt = e_sy_r + CW'(1);
      end else begin
        e_sx_nxt = e_sx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r  <= 1'b0;
      e_sx_r <= '0;
      e_sy_r <= '0;
    end else begin
      e_v_r  <= e_v_nxt;
      e_sx_r <= e_sx_nxt;
      e_sy_r <= e_sy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_op_r   <= in_op;
      e_row0_r <= RCW'(in_pos_y) * RCW'(s_eff);
      e_col0_r <= RCW'(in_pos_x) * RCW'(s_eff);
      e_word_r <= sprw_pkg::encode_rgb(color_mode_r, in_red, in_green, in_blue);
      e_rgb_r  <= sprw_pkg::decode_rgb(color_mode_r, in_raw);
    end
  end

  sprw_pkg::sprw_pay_t e_pay;

  always_comb begin
    if (e_op_r == sprw_pkg::OP_READ) begin
      e_pay.is_write = 1'b0;
      e_pay.word     = '0;
      e_pay.blue     = e_rgb_r[23:16];
      e_pay.green    = e_rgb_r[15:8];
      e_pay.red      = e_rgb_r[7:0];
    end else begin
      e_pay.is_write = 1'b1;
      e_pay.word     = e_word_r;
      e_pay.blue     = '0;
      e_pay.green    = '0;
      e_pay.red      = '0;
    end
    e_pay.last = e_last;
  end

  // stage 1: absolute row and column
  logic [RCW-1:0]      p1_row_r, p1_col_r;
  sprw_pkg::sprw_pay_t p1_pay_r;
  // stage 2: row times stride
  logic [PW-1:0]       p2_prod_r;
  logic [RCW-1:0]      p2_col_r;
  sprw_pkg::sprw_pay_t p2_pay_r;
  // stage 3: pixel index
  logic [IW-1:0]       p3_idx_r;
  sprw_pkg::sprw_pay_t p3_pay_r;
  // stage 4: byte address, output register
  logic [sprw_pkg::ADDR_W-1:0] p4_addr_r;
  sprw_pkg::sprw_pay_t         p4_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else begin
      if (rdy1) p1_v_r <= emit;
      if (rdy2) p2_v_r <= p1_v_r;
      if (rdy3) p3_v_r <= p2_v_r;
      if (rdy4) p4_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_row_r <= e_row0_r + RCW'(e_sy_r);
      p1_col_r <= e_col0_r + RCW'(e_sx_r);
      p1_pay_r <= e_pay;
    end
    if (rdy2) begin
      p2_prod_r <= PW'(p1_row_r) * PW'(stride_r);
      p2_col_r  <= p1_col_r;
      p2_pay_r  <= p1_pay_r;
    end
    if (rdy3) begin
      p3_idx_r <= IW'(p2_prod_r) + IW'(p2_col_r);
      p3_pay_r <= p2_pay_r;
    end
    if (rdy4) begin
      p4_addr_r <= base_r + sprw_pkg::ADDR_W'({p3_idx_r, 2'b00});
      p4_pay_r  <= p3_pay_r;
    end
  end

  assign out_tvalid   = p4_v_r;
  assign out_tdata    = {p4_pay_r.blue, p4_pay_r.green, p4_pay_r.red,
                         p4_pay_r.word, p4_addr_r};
  assign out_tuser[0] = p4_pay_r.is_write;
  assign out_tlast    = p4_pay_r.last;

endmodule

@@ rtl/sprw_checker.sv @@
// ----------------------------------------------------------------------------
// sprw_checker
// Port-level checks on the result stream of the scaled pixel replicate
// writer, bound to the top level.
// ----------------------------------------------------------------------------
module sprw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sprw_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);

  // drop results after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // a read result is always the single, last result of its request
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == 1'b0 |-> out_tlast && out_tdata[79:48] == '0)
    else $error("read result not last or carries a pixel word");

  // a write carries no decoded colour
  a_write_rgb: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == 1'b1 |-> out_tdata[103:80] == '0)
    else $error("write result carries decoded colour");

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind scaled_pixel_replicate_writer sprw_checker u_sprw_checker (.*);
